>>> src/das_pkg.sv
`default_nettype none

package das_pkg;

   localparam int MAX_NODES_DEF = 64;
   localparam int SCORE_W       = 32;
   localparam int NODE_W        = 6;

   // one slot of the sorted store
   typedef struct packed {
      logic signed [SCORE_W-1:0] score;
      logic [NODE_W-1:0]         node;
   } entry_type;

   // controller status, watched at the top level
   typedef struct packed {
      logic emitting;
      logic inserting;
   } status_type;

endpackage

`default_nettype wire

>>> src/das_ifs.sv
`default_nettype none

interface das_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [das_pkg::SCORE_W-1:0]  score;
   logic                                last_score;

   modport source (output valid, output score, output last_score, input ready);
   modport sink   (input valid, input score, input last_score, output ready);
endinterface

interface das_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [das_pkg::NODE_W-1:0]   node_index;
   logic                         last_index;
   logic                         overflow;

   modport source (output valid, output node_index, output last_index, output overflow,
                   input ready);
   modport sink   (input valid, input node_index, input last_index, input overflow,
                   output ready);
endinterface

`default_nettype wire

>>> src/das_store.sv
`default_nettype none

module das_store #(
   parameter int DEPTH = das_pkg::MAX_NODES_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic                clock,
   input  wire logic                wr_en,
   input  wire logic [AW-1:0]       wr_addr,
   input  wire das_pkg::entry_type  wr_entry,
   input  wire logic                rd_en,
   input  wire logic [AW-1:0]       rd_addr,
   output das_pkg::entry_type       rd_entry
);
   import das_pkg::*;

   entry_type mem [DEPTH];
   entry_type rd_entry_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_entry;
      end
      if (rd_en) begin
         rd_entry_ff <= mem[rd_addr];
      end
   end

   assign rd_entry = rd_entry_ff;

endmodule

`default_nettype wire

>>> src/das_ctrl.sv
`default_nettype none

module das_ctrl #(
   parameter int MAX_NODES = das_pkg::MAX_NODES_DEF,
   parameter int AW        = $clog2(MAX_NODES),
   parameter int CW        = $clog2(MAX_NODES + 1)
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   das_req_if.sink                   req_ch,
   das_rsp_if.source                 rsp_ch,
   output logic                      wr_en,
   output logic [AW-1:0]             wr_addr,
   output das_pkg::entry_type        wr_entry,
   output logic                      rd_en,
   output logic [AW-1:0]             rd_addr,
   input  wire das_pkg::entry_type   rd_entry,
   output das_pkg::status_type       status
);
   import das_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE    = 5'b00001,
      ST_SHIFT   = 5'b00010,
      ST_PLACE   = 5'b00100,
      ST_EMIT_RD = 5'b01000,
      ST_EMIT_LD = 5'b10000
   } state_type;

   state_type                 state_ff, state_in;
   logic [CW-1:0]             count_ff, count_in;
   logic                      ovf_ff, ovf_in;
   logic [AW-1:0]             pos_ff, pos_in;
   logic [AW-1:0]             k_ff, k_in;
   logic signed [SCORE_W-1:0] score_ff, score_in;
   logic [NODE_W-1:0]         node_ff, node_in;
   logic                      last_ff, last_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [NODE_W-1:0]         rsp_node_ff, rsp_node_in;
   logic                      rsp_last_ff, rsp_last_in;
   logic                      rsp_ovf_ff, rsp_ovf_in;

   logic                      req_fire;
   logic                      out_free;
   logic                      load_rsp;
   logic                      final_rank;
   logic [CW-1:0]             count_m1;
   logic [CW-1:0]             k_ext;

   assign req_fire   = req_ch.valid && req_ch.ready;
   assign out_free   = !rsp_valid_ff || rsp_ch.ready;
   assign count_m1   = count_ff - CW'(1);
   assign k_ext      = CW'(k_ff);
   assign final_rank = (k_ext == count_m1);

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      ovf_in      = ovf_ff;
      pos_in      = pos_ff;
      k_in        = k_ff;
      score_in    = score_ff;
      node_in     = node_ff;
      last_in     = last_ff;
      rsp_node_in = rsp_node_ff;
      rsp_last_in = rsp_last_ff;
      rsp_ovf_in  = rsp_ovf_ff;
      load_rsp    = 1'b0;
      wr_en       = 1'b0;
      wr_addr     = pos_ff;
      wr_entry    = '{score: score_ff, node: node_ff};
      rd_en       = 1'b0;
      rd_addr     = k_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (count_ff < CW'(MAX_NODES)) begin
                  score_in = req_ch.score;
                  node_in  = NODE_W'(count_ff);
                  pos_in   = count_ff[AW-1:0];
                  last_in  = req_ch.last_score;
                  if (count_ff == '0) begin
                     wr_en    = 1'b1;
                     wr_addr  = '0;
                     wr_entry = '{score: req_ch.score, node: '0};
                     count_in = CW'(1);
                     state_in = req_ch.last_score ? ST_EMIT_RD : ST_IDLE;
                  end else begin
                     // fetch the tail entry, compare next cycle
                     rd_en    = 1'b1;
                     rd_addr  = count_m1[AW-1:0];
                     state_in = ST_SHIFT;
                  end
               end else begin
                  ovf_in   = 1'b1;
                  state_in = req_ch.last_score ? ST_EMIT_RD : ST_IDLE;
               end
            end
         end
         ST_SHIFT: begin
            // rd_entry holds slot pos-1; reads run one slot below the write
            if (rd_entry.score < score_ff) begin
               wr_en    = 1'b1;
               wr_addr  = pos_ff;
               wr_entry = rd_entry;
               pos_in   = pos_ff - AW'(1);
               if (pos_ff == AW'(1)) begin
                  state_in = ST_PLACE;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = pos_ff - AW'(2);
               end
            end else begin
               wr_en    = 1'b1;
               count_in = count_ff + CW'(1);
               state_in = last_ff ? ST_EMIT_RD : ST_IDLE;
            end
         end
         ST_PLACE: begin
            wr_en    = 1'b1;
            count_in = count_ff + CW'(1);
            state_in = last_ff ? ST_EMIT_RD : ST_IDLE;
         end
         ST_EMIT_RD: begin
            rd_en    = 1'b1;
            rd_addr  = k_ff;
            state_in = ST_EMIT_LD;
         end
         ST_EMIT_LD: begin
            if (out_free) begin
               load_rsp    = 1'b1;
               rsp_node_in = rd_entry.node;
               rsp_last_in = final_rank;
               rsp_ovf_in  = ovf_ff;
               if (final_rank) begin
                  count_in = '0;
                  ovf_in   = 1'b0;
                  k_in     = '0;
                  state_in = ST_IDLE;
               end else begin
                  k_in    = k_ff + AW'(1);
                  rd_en   = 1'b1;
                  rd_addr = k_ff + AW'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      score_ff    <= score_in;
      node_ff     <= node_in;
      last_ff     <= last_in;
      rsp_node_ff <= rsp_node_in;
      rsp_last_ff <= rsp_last_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   assign req_ch.ready      = (state_ff == ST_IDLE);
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.node_index = rsp_node_ff;
   assign rsp_ch.last_index = rsp_last_ff;
   assign rsp_ch.overflow   = rsp_ovf_ff;

   assign status.emitting  = (state_ff == ST_EMIT_RD) || (state_ff == ST_EMIT_LD);
   assign status.inserting = (state_ff == ST_SHIFT) || (state_ff == ST_PLACE);

endmodule

`default_nettype wire

>>> src/descending_argsort.sv
// Insert: a score into an empty store, or a score dropped on a full store, is done in the accept.
// Otherwise it takes the accept, then one read-modify-write of the store memory per cycle
// for each of the j stored entries it passes, then a write to place it.
// A new transaction is taken when that ends.
// Emit: after the last score is placed, one index per cycle while the receiver is ready.
// Reset (synchronous, active high) clears the control and output valid; store contents
// are not cleared, only slots below the load count are ever read.
`default_nettype none

module descending_argsort #(
   parameter int MAX_NODES = das_pkg::MAX_NODES_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   das_req_if.sink    req_ch,
   das_rsp_if.source  rsp_ch
);
   import das_pkg::*;

   localparam int AW = $clog2(MAX_NODES);
   localparam int CW = $clog2(MAX_NODES + 1);

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   entry_type     wr_entry;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   entry_type     rd_entry;
   status_type    status;

   das_ctrl #(
      .MAX_NODES (MAX_NODES),
      .AW        (AW),
      .CW        (CW)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .rsp_ch   (rsp_ch),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_entry (wr_entry),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_entry (rd_entry),
      .status   (status)
   );

   das_store #(
      .DEPTH (MAX_NODES),
      .AW    (AW)
   ) u_store (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_entry (wr_entry),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_entry (rd_entry)
   );

   // no input taken while the sorted run is being read out
   a_no_accept_in_emit: assert property (@(posedge clock) disable iff (reset)
      !(req_ch.ready && status.emitting))
      else $error("input ready during emit");

   // a final score always starts the read-out or the insert that precedes it
   a_last_stops_input: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready && req_ch.last_score) |=> !req_ch.ready)
      else $error("input ready right after final score");

   // a fresh result only comes out of the read-out
   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_ch.valid) |-> $past(status.emitting))
      else $error("result raised outside emit");

   // a non-final score either inserts or leaves the block ready
   a_mid_score: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready && !req_ch.last_score)
         |=> (status.inserting || req_ch.ready))
      else $error("unexpected state after score");

endmodule

`default_nettype wire

>>> tb/tb_descending_argsort.sv
`default_nettype none

module tb_descending_argsort;
   import das_pkg::*;

   localparam int MAX_NODES   = MAX_NODES_DEF;
   localparam int IDLE_PCT    = 28;
   localparam int HOLD_CYCLES = 300;
   localparam int QUIET_LIMIT = 2000;
   // scores from the vector loop; the directed vectors bring the rest to about 160
   localparam int RAND_ITEMS  = 138;

   localparam logic signed [SCORE_W-1:0] SCORE_MAX = 32'sh7fff_ffff;
   localparam logic signed [SCORE_W-1:0] SCORE_MIN = 32'sh8000_0000;

   typedef struct {
      logic signed [SCORE_W-1:0] score;
      logic                      fin;
      bit                        calm;
   } score_item_type;

   typedef struct {
      logic [NODE_W-1:0] node;
      logic              fin;
      logic              ovf;
   } rank_type;

   logic clock;
   logic reset;

   das_req_if req_if ();
   das_rsp_if rsp_if ();

   descending_argsort dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   // scores waiting to be offered, ranks waiting to come back
   score_item_type score_q[$];
   rank_type       rank_q[$];

   // sorted store of the current vector, highest score first
   logic signed [SCORE_W-1:0] held_score[MAX_NODES];
   logic [NODE_W-1:0]         held_node[MAX_NODES];
   int                        held_cnt;
   bit                        spilled;

   int  offered, accepted;
   bit  calm_now;
   int  hold_left, holds_wanted, holds_done;
   int  quiet_cycles;
   int  errors;
   int  runs, ovf_runs, ranks_checked, input_stalls;

   always #5 clock = ~clock;

   task automatic report(input string what, input int want, input int got);
      errors++;
      if (errors <= 30)
         $display("mismatch %s: expected %0d got %0d at %0t", what, want, got, $time);
   endtask

   // insertion into the sorted store; on the final score, queue the whole ranking
   task automatic place_score(input logic signed [SCORE_W-1:0] s, input logic fin);
      int       pos;
      rank_type r;
      if (held_cnt < MAX_NODES) begin
         pos = held_cnt;
         while (pos > 0 && held_score[pos-1] < s) begin
            held_score[pos] = held_score[pos-1];
            held_node[pos]  = held_node[pos-1];
            pos--;
         end
         held_score[pos] = s;
         held_node[pos]  = NODE_W'(held_cnt);
         held_cnt++;
      end else begin
         spilled = 1'b1;
      end
      if (fin) begin
         for (int k = 0; k < held_cnt; k++) begin
            r.node = held_node[k];
            r.fin  = (k == held_cnt - 1);
            r.ovf  = spilled;
            rank_q.push_back(r);
         end
         runs++;
         if (spilled)
            ovf_runs++;
         held_cnt = 0;
         spilled  = 1'b0;
      end
   endtask

   task automatic add_score(input logic signed [SCORE_W-1:0] s, input logic fin,
                            input bit calm);
      score_item_type it;
      it.score = s;
      it.fin   = fin;
      it.calm  = calm;
      score_q.push_back(it);
   endtask

   function automatic logic signed [SCORE_W-1:0] pick_score(input int mode);
      int v;
      case (mode)
         0: return $urandom;
         1: begin
            // narrow range forces ties
            v = int'($urandom_range(8)) - 4;
            return v;
         end
         default: begin
            case ($urandom_range(4))
               0: return SCORE_MAX;
               1: return SCORE_MIN;
               2: return 0;
               3: return -1;
               default: return 1;
            endcase
         end
      endcase
   endfunction

   task automatic add_vector(input int len, input bit calm);
      int mode;
      mode = $urandom_range(3);
      for (int i = 0; i < len; i++)
         add_score(pick_score(mode == 3 ? int'($urandom_range(2)) : mode),
                   i == len - 1, calm);
   endtask

   // request driver: one offer at a time, held until taken
   always @(negedge clock) begin : feed
      score_item_type nxt;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!(req_if.valid && offered != accepted)) begin
         if (score_q.size() > 0 && (score_q[0].calm || $urandom_range(99) >= IDLE_PCT)) begin
            nxt = score_q.pop_front();
            req_if.valid      <= 1'b1;
            req_if.score      <= nxt.score;
            req_if.last_score <= nxt.fin;
            calm_now = nxt.calm;
            offered++;
         end else begin
            req_if.valid <= 1'b0;
            if (score_q.size() == 0)
               calm_now = 1'b0;
         end
      end
   end

   // result receiver: random stalls, plus a long hold once results start flowing
   always @(negedge clock) begin : drain
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_if.ready <= 1'b0;
         hold_left--;
      end else if (holds_done < holds_wanted && rsp_if.valid) begin
         hold_left = HOLD_CYCLES;
         holds_done++;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= calm_now || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   always @(posedge clock) begin : watch
      rank_type want;
      bit       moved;
      if (!reset) begin
         moved = 1'b0;
         if (req_if.valid && req_if.ready) begin
            place_score(req_if.score, req_if.last_score);
            accepted++;
            moved = 1'b1;
         end else if (req_if.valid) begin
            input_stalls++;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            moved = 1'b1;
            if (rank_q.size() == 0) begin
               report("unexpected node_index", -1, rsp_if.node_index);
            end else begin
               want = rank_q.pop_front();
               ranks_checked++;
               if (rsp_if.node_index !== want.node)
                  report("node_index", want.node, rsp_if.node_index);
               if (rsp_if.last_index !== want.fin)
                  report("last_index", want.fin, rsp_if.last_index);
               if (rsp_if.overflow !== want.ovf)
                  report("overflow", want.ovf, rsp_if.overflow);
            end
         end
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
      end
   end

   initial begin : watchdog
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
      $display("FAILURE");
      $finish;
   end

   initial begin : stimulus
      int vec_no;
      int rand_items;
      int len;

      clock             = 1'b0;
      reset             = 1'b1;
      req_if.valid      = 1'b0;
      req_if.score      = '0;
      req_if.last_score = 1'b0;
      rsp_if.ready      = 1'b0;
      holds_wanted      = 1;

      // single score that is also last
      add_score(0, 1'b1, 1'b0);
      // extremes with ties at both ends
      add_score(SCORE_MAX, 1'b0, 1'b0);
      add_score(SCORE_MIN, 1'b0, 1'b0);
      add_score(-1, 1'b0, 1'b0);
      add_score(0, 1'b0, 1'b0);
      add_score(1, 1'b0, 1'b0);
      add_score(SCORE_MAX, 1'b0, 1'b0);
      add_score(SCORE_MIN, 1'b0, 1'b0);
      add_score(-1, 1'b1, 1'b0);
      // ascending: every insert walks the whole store
      for (int i = 0; i < 6; i++)
         add_score(i - 3, i == 5, 1'b0);
      // all equal: arrival order must hold
      for (int i = 0; i < 4; i++)
         add_score(5, i == 3, 1'b0);
      // already descending
      add_score(300, 1'b0, 1'b0);
      add_score(-20, 1'b0, 1'b0);
      add_score(SCORE_MIN, 1'b1, 1'b0);

      vec_no     = 0;
      rand_items = 0;
      while (rand_items < RAND_ITEMS) begin
         if (vec_no == 1) begin
            // store filled exactly, sender never idles
            len = MAX_NODES;
            add_vector(len, 1'b1);
         end else if (vec_no == 3) begin
            // overflow: extra scores, last one dropped too
            len = MAX_NODES + 1 + int'($urandom_range(2));
            add_vector(len, 1'b0);
         end else begin
            len = ($urandom_range(9) < 7) ? $urandom_range(1, 8) : $urandom_range(9, 20);
            add_vector(len, 1'b0);
         end
         rand_items += len;
         vec_no++;
      end

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (score_q.size() > 0 || offered != accepted)
         @(posedge clock);
      while (rank_q.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);

      $display("covered %0d vectors (%0d with overflow), %0d scores, %0d indices checked",
               runs, ovf_runs, accepted, ranks_checked);
      $display("input backpressure seen on %0d cycles, %0d long receiver holds, %0d errors",
               input_stalls, holds_done, errors);
      if (errors == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

`default_nettype wire
